// ----- sv/rat_pkg.sv -----
// Shared types and constants of the region address translation table.
`timescale 1ns / 1ps
`default_nettype none

package rat_pkg;

	localparam int ENTRIES_DEF    = 16;
	localparam int PAGE_SHIFT_DEF = 12;
	localparam int ADDR_BITS_DEF  = 48;

	localparam int FIELD_W = 48;
	localparam int KIND_W  = 8;
	localparam int OP_W    = 3;

	localparam logic [OP_W-1:0] OP_INS_PAGES = 3'd0;
	localparam logic [OP_W-1:0] OP_INS_BYTES = 3'd1;
	localparam logic [OP_W-1:0] OP_REMOVE    = 3'd2;
	localparam logic [OP_W-1:0] OP_LOOK_VIRT = 3'd3;
	localparam logic [OP_W-1:0] OP_LOOK_PHYS = 3'd4;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [FIELD_W-1:0] address;
		logic [FIELD_W-1:0] phys_start;
		logic [FIELD_W-1:0] amount;
		logic [KIND_W-1:0]  kind;
	} req_item_t;

	typedef struct packed {
		status_t            status;
		logic [FIELD_W-1:0] result_address;
		logic [FIELD_W-1:0] region_bytes;
		logic [KIND_W-1:0]  found_kind;
	} rsp_item_t;

	// engine handshake toward the top level
	typedef struct packed {
		logic idle;
		logic done;
	} eng_stat_t;

endpackage

`default_nettype wire

// ----- sv/rat_chan_if.sv -----
// Valid/ready channel carrying one payload beat.
`timescale 1ns / 1ps
`default_nettype none

interface rat_chan_if #(
	parameter type item_t = logic
);
	logic  valid;
	logic  ready;
	item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- sv/rat_slot_ram.sv -----
// Slot record memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module rat_slot_ram #(
	parameter int DEPTH = rat_pkg::ENTRIES_DEF,
	parameter int IDX_W = 4,
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [IDX_W-1:0] waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [IDX_W-1:0] raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- sv/rat_engine.sv -----
// Sequencer and shared scan datapath of the translation table.
`timescale 1ns / 1ps
`default_nettype none

module rat_engine #(
	parameter int ENTRIES    = rat_pkg::ENTRIES_DEF,
	parameter int PAGE_SHIFT = rat_pkg::PAGE_SHIFT_DEF,
	parameter int ADDR_BITS  = rat_pkg::ADDR_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire rat_pkg::req_item_t item,
	input  wire logic              take,
	output rat_pkg::eng_stat_t     stat,
	output rat_pkg::rsp_item_t     res
);

	localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int AGW = IW;
	localparam int CW  = $clog2(ENTRIES + 1);
	localparam int PW  = ADDR_BITS - PAGE_SHIFT;
	localparam int NW  = PW + 1;
	localparam logic [IW-1:0] LAST_IDX   = IW'(ENTRIES - 1);
	localparam logic [CW-1:0] FULL_CNT   = CW'(ENTRIES);
	localparam logic [63:0]   PAGE_RND   = (64'(1) << PAGE_SHIFT) - 64'(1);
	localparam logic [63:0]   MAX_PAGES  = 64'(1) << PW;
	localparam logic [63:0]   ADDR_MASK  = (64'(1) << ADDR_BITS) - 64'(1);
	localparam logic [63:0]   FIELD_MAX  = (64'(1) << rat_pkg::FIELD_W) - 64'(1);

	typedef struct packed {
		logic [AGW-1:0]             age;
		logic [rat_pkg::KIND_W-1:0] kind;
		logic [NW-1:0]              count;
		logic [PW-1:0]              phys;
		logic [PW-1:0]              virt;
	} rec_t;

	localparam int RW = $bits(rec_t);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_PREP = 8'b0000_0010,
		S_SCAN = 8'b0000_0100,
		S_INS  = 8'b0000_1000,
		S_FIX  = 8'b0001_0000,
		S_FIN1 = 8'b0010_0000,
		S_FIN2 = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	state_t state_q;

	// control
	logic [ENTRIES-1:0] valid_q;
	logic [CW-1:0]      cnt_q;
	logic [IW-1:0]      ptr_q;
	logic               issue_q;
	logic               act_s1;
	logic               found_q;
	logic               free_found_q;

	// item and datapath
	logic [rat_pkg::OP_W-1:0]    op_q;
	logic [PW-1:0]               ap_q;
	logic [PAGE_SHIFT-1:0]       low_q;
	logic [PW-1:0]               pp_q;
	logic [rat_pkg::FIELD_W-1:0] amount_q;
	logic [rat_pkg::KIND_W-1:0]  kind_q;
	logic [NW-1:0]               pages_q;
	logic                        side_q;
	logic [IW-1:0]               idx_s1;
	logic                        last_s1;
	logic                        vld_s1;
	rec_t                        best_q;
	logic [IW-1:0]               best_idx_q;
	logic [IW-1:0]               free_idx_q;
	logic [PW-1:0]               delta_q;
	logic [rat_pkg::FIELD_W-1:0] bytes_q;
	rat_pkg::rsp_item_t          res_q;

	logic [63:0]   addr64, phys64, amt64, rnd64, raw64, sat64, b64, r64;
	logic [RW-1:0] rd_data;
	rec_t          rec_rd, wrec;
	logic          we, re;
	logic [IW-1:0] waddr;
	logic [PW-1:0] base, from_pg, to_pg;
	logic [NW-1:0] lim, sum;
	logic          hit, better, found_now, is_ins, scan_end;
	logic [IW-1:0] best_idx_now;

	assign addr64 = 64'(item.address);
	assign phys64 = 64'(item.phys_start);
	assign is_ins = (op_q == rat_pkg::OP_INS_PAGES) || (op_q == rat_pkg::OP_INS_BYTES);

	// page count, rounded up from bytes for a byte insert, saturated to the address space
	always_comb begin
		amt64 = 64'(amount_q);
		rnd64 = (amt64 + PAGE_RND) >> PAGE_SHIFT;
		raw64 = (op_q == rat_pkg::OP_INS_BYTES) ? rnd64 : amt64;
		sat64 = (raw64 > MAX_PAGES) ? MAX_PAGES : raw64;
	end

	// shared range compare on one slot per cycle
	always_comb begin
		rec_rd       = rec_t'(rd_data);
		base         = side_q ? rec_rd.phys : rec_rd.virt;
		lim          = {1'b0, base} + rec_rd.count;
		hit          = vld_s1 && (ap_q >= base) && ({1'b0, ap_q} < lim);
		better       = hit && (!found_q || (rec_rd.age < best_q.age));
		found_now    = found_q || better;
		best_idx_now = better ? idx_s1 : best_idx_q;
		scan_end     = act_s1 && last_s1;
	end

	// memory write port
	always_comb begin
		we    = 1'b0;
		waddr = idx_s1;
		wrec  = rec_rd;
		if (state_q == S_SCAN && act_s1 && is_ins && vld_s1) begin
			we       = 1'b1;
			wrec.age = rec_rd.age + AGW'(1);
		end else if (state_q == S_FIX && act_s1 && vld_s1 && (rec_rd.age > best_q.age)) begin
			we       = 1'b1;
			wrec.age = rec_rd.age - AGW'(1);
		end else if (state_q == S_INS) begin
			we         = 1'b1;
			waddr      = free_idx_q;
			wrec.age   = '0;
			wrec.kind  = kind_q;
			wrec.count = pages_q;
			wrec.phys  = pp_q;
			wrec.virt  = ap_q;
		end
	end

	assign re = issue_q && (state_q == S_SCAN || state_q == S_FIX);

	rat_slot_ram #(
		.DEPTH (ENTRIES),
		.IDX_W (IW),
		.WIDTH (RW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (RW'(wrec)),
		.re    (re),
		.raddr (ptr_q),
		.rdata (rd_data)
	);

	// translation of the matched slot
	always_comb begin
		from_pg = side_q ? best_q.phys : best_q.virt;
		to_pg   = side_q ? best_q.virt : best_q.phys;
		b64     = 64'(best_q.count) << PAGE_SHIFT;
		sum     = {1'b0, to_pg} + {1'b0, delta_q};
		r64     = sum[PW] ? ADDR_MASK : 64'({sum[PW-1:0], low_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			cnt_q        <= '0;
			ptr_q        <= '0;
			issue_q      <= 1'b0;
			act_s1       <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			act_s1 <= re;
			if (re) begin
				ptr_q <= ptr_q + IW'(1);
				if (ptr_q == LAST_IDX) begin
					issue_q <= 1'b0;
				end
			end
			if (state_q == S_SCAN && act_s1) begin
				if (better) begin
					found_q <= 1'b1;
				end
				if (is_ins && !vld_s1 && !free_found_q) begin
					free_found_q <= 1'b1;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					found_q      <= 1'b0;
					free_found_q <= 1'b0;
					ptr_q        <= '0;
					unique case (op_q) inside
						rat_pkg::OP_INS_PAGES, rat_pkg::OP_INS_BYTES: begin
							if (cnt_q == FULL_CNT) begin
								state_q <= S_DONE;
							end else begin
								state_q <= S_SCAN;
								issue_q <= 1'b1;
							end
						end
						rat_pkg::OP_REMOVE, rat_pkg::OP_LOOK_VIRT,
						rat_pkg::OP_LOOK_PHYS: begin
							state_q <= S_SCAN;
							issue_q <= 1'b1;
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_SCAN: begin
					if (scan_end) begin
						if (is_ins) begin
							state_q <= S_INS;
						end else if (!found_now) begin
							state_q <= S_DONE;
						end else if (op_q == rat_pkg::OP_REMOVE) begin
							// second pass closes the age gap
							valid_q[best_idx_now] <= 1'b0;
							cnt_q                 <= cnt_q - CW'(1);
							ptr_q                 <= '0;
							issue_q               <= 1'b1;
							state_q               <= S_FIX;
						end else begin
							state_q <= S_FIN1;
						end
					end
				end
				S_INS: begin
					valid_q[free_idx_q] <= 1'b1;
					cnt_q               <= cnt_q + CW'(1);
					state_q             <= S_DONE;
				end
				S_FIX: begin
					if (scan_end) begin
						state_q <= S_DONE;
					end
				end
				S_FIN1: begin
					state_q <= S_FIN2;
				end
				S_FIN2: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q     <= item.operation;
			amount_q <= item.amount;
			kind_q   <= item.kind;
			ap_q     <= addr64[ADDR_BITS-1:PAGE_SHIFT];
			low_q    <= addr64[PAGE_SHIFT-1:0];
			pp_q     <= phys64[ADDR_BITS-1:PAGE_SHIFT];
			side_q   <= (item.operation == rat_pkg::OP_LOOK_PHYS);
		end
		if (state_q == S_PREP) begin
			pages_q <= sat64[NW-1:0];
			res_q   <= '{
				status:         (is_ins && cnt_q == FULL_CNT) ? rat_pkg::ST_FULL
				                                              : rat_pkg::ST_NOT_FOUND,
				result_address: '0,
				region_bytes:   '0,
				found_kind:     '0
			};
		end
		idx_s1  <= ptr_q;
		last_s1 <= (ptr_q == LAST_IDX);
		vld_s1  <= valid_q[ptr_q];
		if (state_q == S_SCAN && act_s1) begin
			if (better) begin
				best_q     <= rec_rd;
				best_idx_q <= idx_s1;
			end
			if (is_ins && !vld_s1 && !free_found_q) begin
				free_idx_q <= idx_s1;
			end
			if (scan_end && op_q == rat_pkg::OP_REMOVE && found_now) begin
				res_q.status <= rat_pkg::ST_OK;
			end
		end
		if (state_q == S_INS) begin
			res_q.status <= rat_pkg::ST_OK;
		end
		if (state_q == S_FIN1) begin
			delta_q <= ap_q - from_pg;
			bytes_q <= (b64 > FIELD_MAX) ? '1 : b64[rat_pkg::FIELD_W-1:0];
		end
		if (state_q == S_FIN2) begin
			res_q.status         <= rat_pkg::ST_OK;
			res_q.result_address <= r64[rat_pkg::FIELD_W-1:0];
			res_q.region_bytes   <= side_q ? '0 : bytes_q;
			res_q.found_kind     <= side_q ? '0 : best_q.kind;
		end
	end

	assign stat.idle = (state_q == S_IDLE);
	assign stat.done = (state_q == S_DONE);
	assign res       = res_q;

endmodule

`default_nettype wire

// ----- sv/region_address_translation_table.sv -----
// One item is processed at a time: a new request beat is accepted only while the engine is
// idle, after the previous result has been handed to the output register. Inserts, lookups
// and removes scan every slot, reading one record per cycle; a remove that hits makes a
// second pass to close the age gap, and a full-table insert or an unknown operation skips
// the scan. A waiting result lets the next beat in.
// Reset clears all slot valid bits at once; slot records need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module region_address_translation_table #(
	parameter int ENTRIES    = rat_pkg::ENTRIES_DEF,
	parameter int PAGE_SHIFT = rat_pkg::PAGE_SHIFT_DEF,
	parameter int ADDR_BITS  = rat_pkg::ADDR_BITS_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	rat_chan_if.sink    req,
	rat_chan_if.source  rsp
);

	rat_pkg::eng_stat_t stat;
	rat_pkg::rsp_item_t eng_res;
	rat_pkg::rsp_item_t rsp_data_q;
	logic               rsp_valid_q;
	logic               take;

	assign req.ready = stat.idle;
	assign take      = !rsp_valid_q || rsp.ready;

	rat_engine #(
		.ENTRIES    (ENTRIES),
		.PAGE_SHIFT (PAGE_SHIFT),
		.ADDR_BITS  (ADDR_BITS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (req.valid && req.ready),
		.item   (req.payload),
		.take   (take),
		.stat   (stat),
		.res    (eng_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (stat.done && take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done && take) begin
			rsp_data_q <= eng_res;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_data_q;

endmodule

`default_nettype wire
